/* hdl/bra_pkg.sv */
package bra_pkg;

	// default geometry of the bitmap
	localparam int WORD_WIDTH_DEF = 32;
	localparam int WORD_COUNT_DEF = 32;

	// fixed field widths
	localparam int ACTION_W = 3;
	localparam int INDEX_W  = 10;
	localparam int LEN_W    = 11;
	localparam int CFG_W    = 6;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	// register map, indexed by paddr[2]
	localparam logic REG_WORDS_IN_USE = 1'b0;
	localparam int   WORDS_RESET      = 32;

	// shift used by the reciprocal word-index multiply
	localparam int RECIP_SHIFT = 20;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		ACT_TEST  = 3'd0,
		ACT_SET   = 3'd1,
		ACT_CLEAR = 3'd2,
		ACT_FIND  = 3'd3,
		ACT_WIPE  = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		OP_TEST,
		OP_SET,
		OP_CLEAR,
		OP_FIND,
		OP_WIPE,
		OP_ERROR,
		OP_NOP
	} op_kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_FIND,
		ST_WIPE
	} st_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [INDEX_W-1:0]  bit_index;
		logic [LEN_W-1:0]    run_length;
	} req_t;

	typedef struct packed {
		logic               bit_value;
		logic               found;
		logic [INDEX_W-1:0] start_index;
		logic               index_error;
	} res_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [INDEX_W-1:0] index;
		logic [LEN_W-1:0]   length;
	} op_t;

	typedef struct packed {
		logic full;
		logic init_busy;
	} front_stat_t;

endpackage

/* hdl/bra_ram.sv */
module bra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/bra_queue.sv */
module bra_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bra_pkg::op_t  push_op,
	input  logic          pop,
	output logic          full,
	output logic          valid,
	output bra_pkg::op_t  head
);

	localparam int PW = (bra_pkg::QUEUE_DEPTH > 1) ? $clog2(bra_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(bra_pkg::QUEUE_DEPTH + 1);

	bra_pkg::op_t   ent_q [bra_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(bra_pkg::QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = ent_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(bra_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(bra_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

/* hdl/bra_front.sv */
module bra_front #(
	parameter int WORD_WIDTH = bra_pkg::WORD_WIDTH_DEF,
	parameter int WORD_COUNT = bra_pkg::WORD_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  bra_pkg::req_t                        req,
	input  bra_pkg::front_stat_t                 stat,
	output logic                                 push,
	output bra_pkg::op_t                         push_op,
	output logic [$clog2(WORD_COUNT + 1)-1:0]    nwords,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [bra_pkg::APB_AW-1:0]           paddr,
	input  logic [bra_pkg::APB_DW-1:0]           pwdata,
	output logic [bra_pkg::APB_DW-1:0]           prdata,
	output logic                                 pready
);

	localparam int NW_W   = $clog2(WORD_COUNT + 1);
	localparam int TB_W   = $clog2(WORD_COUNT * WORD_WIDTH + 1);
	localparam int NW_RST = (bra_pkg::WORDS_RESET > WORD_COUNT) ? WORD_COUNT
	                        : bra_pkg::WORDS_RESET;

	logic [bra_pkg::CFG_W-1:0] words_q;
	logic [NW_W-1:0]           nwords_q;
	logic [TB_W-1:0]           total_q;
	logic [NW_W-1:0]           nwords_d;
	logic                      cfg_wr;
	logic                      idx_bad;
	logic                      len_bad;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == bra_pkg::REG_WORDS_IN_USE);
	assign prdata = (paddr[2] == bra_pkg::REG_WORDS_IN_USE)
	                ? bra_pkg::APB_DW'(words_q) : '0;
	assign nwords = nwords_q;

	// saturate the word count to the store depth
	assign nwords_d = (int'(pwdata[bra_pkg::CFG_W-1:0]) > WORD_COUNT)
	                  ? NW_W'(WORD_COUNT) : NW_W'(pwdata[bra_pkg::CFG_W-1:0]);

	// configuration register and derived bit total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q  <= bra_pkg::CFG_W'(bra_pkg::WORDS_RESET);
			nwords_q <= NW_W'(NW_RST);
			total_q  <= TB_W'(NW_RST * WORD_WIDTH);
		end else if (cfg_wr) begin
			words_q  <= pwdata[bra_pkg::CFG_W-1:0];
			nwords_q <= nwords_d;
			total_q  <= TB_W'(nwords_d * WORD_WIDTH);
		end
	end

	// request acceptance
	assign busy = stat.full || stat.init_busy;
	assign push = start && !busy;

	// classify the request
	assign idx_bad = int'(req.bit_index) >= int'(total_q);
	assign len_bad = (req.run_length == '0) || (int'(req.run_length) > int'(total_q));

	always_comb begin
		push_op.index  = req.bit_index;
		push_op.length = req.run_length;
		case (req.action)
			bra_pkg::ACT_TEST:  push_op.kind = idx_bad ? bra_pkg::OP_ERROR : bra_pkg::OP_TEST;
			bra_pkg::ACT_SET:   push_op.kind = idx_bad ? bra_pkg::OP_ERROR : bra_pkg::OP_SET;
			bra_pkg::ACT_CLEAR: push_op.kind = idx_bad ? bra_pkg::OP_ERROR : bra_pkg::OP_CLEAR;
			bra_pkg::ACT_FIND:  push_op.kind = len_bad ? bra_pkg::OP_NOP : bra_pkg::OP_FIND;
			bra_pkg::ACT_WIPE:  push_op.kind = bra_pkg::OP_WIPE;
			default:            push_op.kind = bra_pkg::OP_NOP;
		endcase
	end

endmodule

/* hdl/bra_back.sv */
module bra_back #(
	parameter int WORD_WIDTH = bra_pkg::WORD_WIDTH_DEF,
	parameter int WORD_COUNT = bra_pkg::WORD_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  bra_pkg::op_t                      q_head,
	output logic                              q_pop,
	input  logic [$clog2(WORD_COUNT + 1)-1:0] nwords,
	output logic                              init_busy,
	output logic                              done,
	output bra_pkg::res_t                     rsp
);

	localparam int AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int NW_W  = $clog2(WORD_COUNT + 1);
	localparam int TB_W  = $clog2(WORD_COUNT * WORD_WIDTH + 1);
	localparam int OW    = $clog2(WORD_WIDTH);
	localparam int TZ_W  = $clog2(WORD_WIDTH + 1);
	localparam int RECIP = (2 ** bra_pkg::RECIP_SHIFT + WORD_WIDTH - 1) / WORD_WIDTH;
	localparam int RP_W  = bra_pkg::INDEX_W + bra_pkg::RECIP_SHIFT;

	bra_pkg::st_t   st_q, st_d;
	bra_pkg::op_t   cur_q, cur_d;
	logic [AW-1:0]  word_q, word_d;
	logic [NW_W-1:0] pa_q, pa_d;
	logic [NW_W-1:0] ra_q, ra_d;
	logic [TB_W-1:0] run_q, run_d;
	logic [TB_W-1:0] base_q, base_d;
	logic [AW-1:0]  cnt_q, cnt_d;
	logic           done_q, done_d;
	bra_pkg::res_t  rsp_q, rsp_d;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [WORD_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [WORD_WIDTH-1:0] ram_rdata;

	logic [RP_W-1:0]       recip_prod;
	logic [AW-1:0]         word_calc;
	logic [OW-1:0]         offset;
	logic [WORD_WIDTH-1:0] bit_sel;
	logic [WORD_WIDTH-1:0] len_mask;
	logic [WORD_WIDTH-1:0] fit;
	logic                  inner_hit;
	logic [OW-1:0]         inner_p;
	logic [TZ_W-1:0]       tz;
	logic [TZ_W-1:0]       lz;
	logic                  carry_ok;
	logic [TB_W-1:0]       new_run;

	bra_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (WORD_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// word index of the queued bit by reciprocal multiply
	assign recip_prod = RP_W'(q_head.index) * RP_W'(RECIP);
	assign word_calc  = AW'(recip_prod >> bra_pkg::RECIP_SHIFT);

	// bit offset inside the addressed word
	assign offset = OW'(({1'b0, cur_q.index}) - (bra_pkg::INDEX_W + 1)'(word_q * WORD_WIDTH));

	always_comb begin
		for (int j = 0; j < WORD_WIDTH; j++) begin
			bit_sel[j]  = (OW'(j) == offset);
			len_mask[j] = (j < int'(cur_q.length));
		end
	end

	// runs lying wholly inside the current word
	always_comb begin
		for (int p = 0; p < WORD_WIDTH; p++) begin
			fit[p] = ((p + int'(cur_q.length)) <= WORD_WIDTH)
			         && (((ram_rdata >> p) & len_mask) == '0);
		end
	end

	// lowest fitting start, trailing and leading free counts
	always_comb begin
		inner_hit = 1'b0;
		inner_p   = '0;
		tz        = TZ_W'(WORD_WIDTH);
		lz        = TZ_W'(WORD_WIDTH);
		for (int p = WORD_WIDTH - 1; p >= 0; p--) begin
			if (fit[p]) begin
				inner_hit = 1'b1;
				inner_p   = OW'(p);
			end
			if (ram_rdata[p]) begin
				tz = TZ_W'(p);
			end
		end
		for (int j = 0; j < WORD_WIDTH; j++) begin
			if (ram_rdata[j]) begin
				lz = TZ_W'(WORD_WIDTH - 1 - j);
			end
		end
	end

	// run carried in from lower words completes here
	assign carry_ok = (int'(cur_q.length) - int'(run_q)) <= int'(tz);
	assign new_run  = (ram_rdata == '0) ? TB_W'(run_q + TB_W'(WORD_WIDTH)) : TB_W'(lz);

	// sequencer: next state, memory access and result
	always_comb begin
		st_d      = st_q;
		cur_d     = cur_q;
		word_d    = word_q;
		pa_d      = pa_q;
		ra_d      = ra_q;
		run_d     = run_q;
		base_d    = base_q;
		cnt_d     = cnt_q;
		done_d    = 1'b0;
		rsp_d     = '0;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = word_calc;
		case (st_q)
			bra_pkg::ST_INIT, bra_pkg::ST_WIPE: begin
				ram_we = 1'b1;
				cnt_d  = AW'(cnt_q + 1'b1);
				if (cnt_q == AW'(WORD_COUNT - 1)) begin
					cnt_d  = '0;
					st_d   = bra_pkg::ST_IDLE;
					done_d = (st_q == bra_pkg::ST_WIPE);
				end
			end
			bra_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					cur_d = q_head;
					case (q_head.kind)
						bra_pkg::OP_TEST, bra_pkg::OP_SET, bra_pkg::OP_CLEAR: begin
							ram_re = 1'b1;
							word_d = word_calc;
							st_d   = bra_pkg::ST_RD;
						end
						bra_pkg::OP_FIND: begin
							ram_re    = 1'b1;
							ram_raddr = '0;
							ra_d      = NW_W'(1);
							pa_d      = '0;
							run_d     = '0;
							base_d    = '0;
							st_d      = bra_pkg::ST_FIND;
						end
						bra_pkg::OP_WIPE: begin
							cnt_d = '0;
							st_d  = bra_pkg::ST_WIPE;
						end
						bra_pkg::OP_ERROR: begin
							done_d            = 1'b1;
							rsp_d.index_error = 1'b1;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			bra_pkg::ST_RD: begin
				ram_waddr = word_q;
				done_d    = 1'b1;
				st_d      = bra_pkg::ST_IDLE;
				case (cur_q.kind)
					bra_pkg::OP_SET: begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata | bit_sel;
					end
					bra_pkg::OP_CLEAR: begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata & ~bit_sel;
					end
					default: begin
						rsp_d.bit_value = |(ram_rdata & bit_sel);
					end
				endcase
			end
			bra_pkg::ST_FIND: begin
				ram_re    = (ra_q < nwords);
				ram_raddr = ra_q[AW-1:0];
				ra_d      = NW_W'(ra_q + 1'b1);
				if (carry_ok) begin
					done_d            = 1'b1;
					rsp_d.found       = 1'b1;
					rsp_d.start_index = bra_pkg::INDEX_W'(TB_W'(base_q - run_q));
					st_d              = bra_pkg::ST_IDLE;
				end else if (inner_hit) begin
					done_d            = 1'b1;
					rsp_d.found       = 1'b1;
					rsp_d.start_index = bra_pkg::INDEX_W'(TB_W'(base_q + TB_W'(inner_p)));
					st_d              = bra_pkg::ST_IDLE;
				end else if (NW_W'(pa_q + 1'b1) == nwords) begin
					done_d = 1'b1;
					st_d   = bra_pkg::ST_IDLE;
				end else begin
					pa_d   = NW_W'(pa_q + 1'b1);
					base_d = TB_W'(base_q + TB_W'(WORD_WIDTH));
					run_d  = new_run;
				end
			end
			default: begin
				st_d = bra_pkg::ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= bra_pkg::ST_INIT;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			cnt_q  <= cnt_d;
			done_q <= done_d;
		end
	end

	// operation context and result payload
	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		word_q <= word_d;
		pa_q   <= pa_d;
		ra_q   <= ra_d;
		run_q  <= run_d;
		base_q <= base_d;
		rsp_q  <= rsp_d;
	end

	assign init_busy = (st_q == bra_pkg::ST_INIT);
	assign done      = done_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_found_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.found |-> !rsp_q.index_error && !rsp_q.bit_value)
		else $error("find result carries test or error flags");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == bra_pkg::ST_FIND |-> pa_q < nwords)
		else $error("find scan beyond words in use");
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (st_q == bra_pkg::ST_INIT || st_q == bra_pkg::ST_WIPE
		            || st_q == bra_pkg::ST_RD))
		else $error("bitmap written outside clear or modify");
	a_init_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		$past(st_q) == bra_pkg::ST_INIT |-> !done_q)
		else $error("result produced by power-up clear");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> st_q == bra_pkg::ST_IDLE && q_valid)
		else $error("queue popped while busy or empty");
`endif

endmodule

/* hdl/bitmap_run_allocator.sv */
// one request executes at a time; test/set/clear read the addressed word and then
// write it back or report the bit, an out-of-range index or no-op reports without
// touching the bitmap, a find scans the words in use one word per cycle, and clear
// all writes every word; a two-entry request queue accepts requests while one executes;
// after reset the bitmap is swept to zero with busy high; the receiver cannot stall
module bitmap_run_allocator #(
	parameter int WORD_WIDTH = bra_pkg::WORD_WIDTH_DEF,
	parameter int WORD_COUNT = bra_pkg::WORD_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  bra_pkg::req_t              req,
	output logic                       done,
	output bra_pkg::res_t              rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bra_pkg::APB_AW-1:0] paddr,
	input  logic [bra_pkg::APB_DW-1:0] pwdata,
	output logic [bra_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	localparam int NW_W = $clog2(WORD_COUNT + 1);

	bra_pkg::front_stat_t stat;
	logic                 push;
	bra_pkg::op_t         push_op;
	logic                 q_pop;
	logic                 q_valid;
	bra_pkg::op_t         q_head;
	logic [NW_W-1:0]      nwords;

	bra_front #(
		.WORD_WIDTH (WORD_WIDTH),
		.WORD_COUNT (WORD_COUNT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.stat    (stat),
		.push    (push),
		.push_op (push_op),
		.nwords  (nwords),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bra_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (q_pop),
		.full    (stat.full),
		.valid   (q_valid),
		.head    (q_head)
	);

	bra_back #(
		.WORD_WIDTH (WORD_WIDTH),
		.WORD_COUNT (WORD_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.nwords    (nwords),
		.init_busy (stat.init_busy),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

/* tb/sv/tb_bitmap_run_allocator.sv */
`timescale 1ns / 1ps

module tb_bitmap_run_allocator;

	localparam int WW = bra_pkg::WORD_WIDTH_DEF;
	localparam int WC = bra_pkg::WORD_COUNT_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	bra_pkg::req_t req;
	logic done;
	bra_pkg::res_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [bra_pkg::APB_AW-1:0] paddr;
	logic [bra_pkg::APB_DW-1:0] pwdata;
	logic [bra_pkg::APB_DW-1:0] prdata;
	logic pready;

	// bitmap mirror and register copy
	logic [WW-1:0] bitmap_mirror [WC];
	logic [bra_pkg::CFG_W-1:0] words_cfg;
	bra_pkg::res_t result_queue [$];
	int fail_count;
	int idle_pct;
	int quiet_cycles;

	bitmap_run_allocator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// compute expected result and update the mirror
	function automatic bra_pkg::res_t predict_op(bra_pkg::req_t r);
		bra_pkg::res_t o;
		int total;
		int run;
		int w;
		o = '0;
		w = (words_cfg > WC) ? WC : words_cfg;
		total = w * WW;
		if (r.action <= bra_pkg::ACT_CLEAR) begin
			if (r.bit_index >= total) begin
				o.index_error = 1'b1;
			end else if (r.action == bra_pkg::ACT_TEST) begin
				o.bit_value = bitmap_mirror[r.bit_index / WW][r.bit_index % WW];
			end else begin
				bitmap_mirror[r.bit_index / WW][r.bit_index % WW] =
					(r.action == bra_pkg::ACT_SET);
			end
		end else if (r.action == bra_pkg::ACT_FIND) begin
			if (r.run_length != 0 && r.run_length <= total) begin
				run = 0;
				for (int i = 0; i < total; i++) begin
					if (bitmap_mirror[i / WW][i % WW]) begin
						run = 0;
					end else begin
						run++;
						if (run == r.run_length) begin
							o.found = 1'b1;
							o.start_index = bra_pkg::INDEX_W'(i + 1 - int'(r.run_length));
							break;
						end
					end
				end
			end
		end else if (r.action == bra_pkg::ACT_WIPE) begin
			for (int i = 0; i < WC; i++) bitmap_mirror[i] = '0;
		end
		return o;
	endfunction

	// result checker
	always @(posedge clk) begin
		bra_pkg::res_t e;
		if (arst_n && done) begin
			if (result_queue.size() == 0) begin
				$error("result with no request pending");
				fail_count++;
			end else begin
				e = result_queue.pop_front();
				if (rsp.bit_value !== e.bit_value) begin
					$error("bit_value exp %0d got %0d", e.bit_value, rsp.bit_value);
					fail_count++;
				end
				if (rsp.found !== e.found) begin
					$error("found exp %0d got %0d", e.found, rsp.found);
					fail_count++;
				end
				if (rsp.start_index !== e.start_index) begin
					$error("start_index exp %0d got %0d", e.start_index, rsp.start_index);
					fail_count++;
				end
				if (rsp.index_error !== e.index_error) begin
					$error("index_error exp %0d got %0d", e.index_error, rsp.index_error);
					fail_count++;
				end
			end
		end
	end

	// watchdog on accepted requests and results
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// start stays high after a request until the next request, idle gap or drain
	task automatic send_request(input logic [2:0] act, input int idx, input int len);
		bra_pkg::req_t r;
		r.action = act;
		r.bit_index = bra_pkg::INDEX_W'(idx);
		r.run_length = bra_pkg::LEN_W'(len);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		result_queue.push_back(predict_op(r));
		@(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (result_queue.size() != 0) @(negedge clk);
		repeat (WC + 8) @(negedge clk);
	endtask

	task automatic write_words(input int val);
		drain_results();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {bra_pkg::REG_WORDS_IN_USE, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		words_cfg = val[bra_pkg::CFG_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_request(input int nbits);
		int a;
		int idx;
		a = $urandom_range(99);
		idx = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(nbits);
		if (a < 25) send_request(bra_pkg::ACT_TEST, idx, $urandom_range(2047));
		else if (a < 55) send_request(bra_pkg::ACT_SET, idx, $urandom_range(2047));
		else if (a < 70) send_request(bra_pkg::ACT_CLEAR, idx, $urandom_range(2047));
		else if (a < 93) send_request(bra_pkg::ACT_FIND, $urandom_range(1023),
			($urandom_range(4) == 0) ? $urandom_range(2047) : $urandom_range(1, 40));
		else if (a < 95) send_request(bra_pkg::ACT_WIPE, $urandom_range(1023),
			$urandom_range(2047));
		else send_request(3'($urandom_range(5, 7)), $urandom_range(1023), $urandom_range(2047));
	endtask

	task automatic test_directed();
		idle_pct = 0;
		send_request(bra_pkg::ACT_TEST, 0, 0);
		send_request(bra_pkg::ACT_SET, 0, 2047);
		send_request(bra_pkg::ACT_SET, 1023, 0);
		send_request(bra_pkg::ACT_TEST, 1023, 0);
		send_request(bra_pkg::ACT_FIND, 0, 0);
		send_request(bra_pkg::ACT_FIND, 0, 1);
		send_request(bra_pkg::ACT_FIND, 0, 1022);
		send_request(bra_pkg::ACT_FIND, 0, 1023);
		send_request(bra_pkg::ACT_FIND, 0, 1024);
		send_request(bra_pkg::ACT_FIND, 0, 1025);
		send_request(bra_pkg::ACT_CLEAR, 0, 0);
		send_request(bra_pkg::ACT_FIND, 0, 1024);
		send_request(3'd5, 1023, 2047);
		send_request(3'd7, 5, 5);
		send_request(bra_pkg::ACT_WIPE, 0, 0);
		send_request(bra_pkg::ACT_TEST, 1023, 0);
		write_words(0);
		send_request(bra_pkg::ACT_SET, 0, 0);
		send_request(bra_pkg::ACT_FIND, 0, 1);
		write_words(63);
		send_request(bra_pkg::ACT_SET, 1023, 0);
		send_request(bra_pkg::ACT_TEST, 1023, 0);
		write_words(1);
		send_request(bra_pkg::ACT_SET, 32, 0);
		send_request(bra_pkg::ACT_FIND, 0, 32);
		send_request(bra_pkg::ACT_FIND, 0, 33);
	endtask

	task automatic test_random(input int cfg, input int pct, input int count);
		int w;
		write_words(cfg);
		idle_pct = pct;
		w = (cfg > WC) ? WC : cfg;
		for (int i = 0; i < count; i++) random_request((w == 0) ? 40 : w * WW);
	endtask

	task automatic test_pause();
		idle_pct = 0;
		for (int i = 0; i < 10; i++) random_request(64);
		drain_results();
		for (int i = 0; i < 10; i++) random_request(64);
	endtask

	initial begin
		fail_count = 0;
		idle_pct = 0;
		quiet_cycles = 0;
		words_cfg = bra_pkg::CFG_W'(bra_pkg::WORDS_RESET);
		for (int i = 0; i < WC; i++) bitmap_mirror[i] = '0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(2, 0, 140);
		test_random(32, 59, 140);
		test_random(1, 20, 140);
		test_random(5, 0, 120);
		test_pause();
		test_random(40, 59, 120);
		drain_results();
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

/* bitmap_run_allocator.f */
hdl/bra_pkg.sv
hdl/bra_ram.sv
hdl/bra_queue.sv
hdl/bra_front.sv
hdl/bra_back.sv
hdl/bitmap_run_allocator.sv
tb/sv/tb_bitmap_run_allocator.sv
